@@ rtl/core/assert_macros.svh @@
// assertion macros for the rtl files, used by the load/store unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// condition that must never hold outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`endif

@@ rtl/core/cbmlsu_pkg.sv @@
// types and constants of the checked byte memory load/store unit
`timescale 1ns / 1ps

package cbmlsu_pkg;

  // access kinds carried on in_tuser
  typedef enum logic [2:0] {
    FUNC_LW  = 3'd0,
    FUNC_LH  = 3'd1,
    FUNC_LHU = 3'd2,
    FUNC_LB  = 3'd3,
    FUNC_LBU = 3'd4,
    FUNC_SW  = 3'd5,
    FUNC_SH  = 3'd6,
    FUNC_SB  = 3'd7
  } func_t;

  // controller states: memory clearing after reset, then normal service
  typedef enum logic {
    ST_CLEAR = 1'b0,
    ST_RUN   = 1'b1
  } state_t;

  localparam int IN_TDATA_W  = 64;
  localparam int IN_TUSER_W  = 3;
  localparam int OUT_TDATA_W = 32;
  localparam int OUT_TUSER_W = 2;

endpackage

@@ rtl/core/checked_byte_memory_load_store_unit.sv @@
// data memory stage: checked big-endian byte memory with load and store
`timescale 1ns / 1ps
// result: a result beat appears in the cycle after its input beat is accepted
// throughput: one access per cycle while out_tready is high; the word-wide memory is read
//   or written at the accept edge, and out_tready backs up into in_tready
// reset: a clearing pass writes zero to all ceil(MEM_BYTES/4) memory words
//   (256 at the default size), with in_tready low until it finishes
module checked_byte_memory_load_store_unit #(
  parameter int MEM_BYTES = 1024
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // address [31:0], write_data [63:32]
  input  logic [cbmlsu_pkg::IN_TDATA_W-1:0]   in_tdata,
  // func [2:0]
  input  logic [cbmlsu_pkg::IN_TUSER_W-1:0]   in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // read_data [31:0]
  output logic [cbmlsu_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // address_out_of_range [0], misaligned [1]
  output logic [cbmlsu_pkg::OUT_TUSER_W-1:0]  out_tuser
);
  import cbmlsu_pkg::*;

  localparam int WORDS = (MEM_BYTES + 3) / 4;
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;

  // word memory, byte lane 3 holds the lowest byte address of the word
  logic [31:0] mem [WORDS];

  state_t          state_r, state_nxt;
  logic [AW-1:0]   clr_cnt_r, clr_cnt_nxt;
  logic            clearing;

  logic            out_valid_r, out_valid_nxt;
  func_t           s_func_r;
  logic            s_oor_r, s_mis_r;
  logic [1:0]      s_off_r;
  logic [31:0]     rd_word_r;
  logic [31:0]     held_r, held_nxt;

  func_t           in_func;
  logic signed [31:0] in_address;
  logic [31:0]     in_wdata;
  logic [1:0]      size_m1;
  logic [31:0]     last_byte;
  logic            acc_oor, acc_mis, acc_ok, acc_load, in_beat;
  logic [AW-1:0]   acc_idx;
  logic [31:0]     st_data;
  logic [3:0]      st_be;
  logic            mem_we;
  logic [AW-1:0]   mem_widx;
  logic [31:0]     mem_wdata;
  logic [3:0]      mem_be;

  logic            s_ok, s_load;
  logic [15:0]     ld_half;
  logic [7:0]      ld_byte;
  logic [31:0]     read_data;

  // input field unpacking
  assign in_func    = func_t'(in_tuser[2:0]);
  assign in_address = in_tdata[31:0];
  assign in_wdata   = in_tdata[63:32];

  // next state of the clearing sequencer
  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    case (state_r)
      ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + AW'(1);
        if (clr_cnt_r == AW'(WORDS - 1)) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        clr_cnt_nxt = clr_cnt_r;
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  // state decoded outputs
  always_comb begin
    case (state_r)
      ST_CLEAR: clearing = 1'b1;
      ST_RUN:   clearing = 1'b0;
      default:  clearing = 1'b1;
    endcase
  end

  assign in_tready = !clearing && (!out_valid_r || out_tready);
  assign in_beat   = in_tvalid && in_tready;

  // access size and range checks
  always_comb begin
    case (in_func)
      FUNC_LW, FUNC_SW:           size_m1 = 2'd3;
      FUNC_LH, FUNC_LHU, FUNC_SH: size_m1 = 2'd1;
      default:                    size_m1 = 2'd0;
    endcase
  end

  assign last_byte = {1'b0, in_address[30:0]} + 32'(size_m1);
  assign acc_oor   = in_address[31] || (last_byte >= 32'(MEM_BYTES));
  assign acc_mis   = (in_address[1:0] & size_m1) != 2'b00;
  assign acc_ok    = !acc_oor && !acc_mis;
  assign acc_load  = (in_func != FUNC_SW) && (in_func != FUNC_SH) && (in_func != FUNC_SB);
  assign acc_idx   = in_address[AW+1:2];

  // store lanes, big-endian within the word
  always_comb begin
    case (in_func)
      FUNC_SW: begin
        st_data = in_wdata;
        st_be   = 4'b1111;
      end
      FUNC_SH: begin
        st_data = {in_wdata[15:0], in_wdata[15:0]};
        st_be   = in_address[1] ? 4'b0011 : 4'b1100;
      end
      FUNC_SB: begin
        st_data = {4{in_wdata[7:0]}};
        st_be   = 4'b1000 >> in_address[1:0];
      end
      default: begin
        st_data = in_wdata;
        st_be   = 4'b0000;
      end
    endcase
  end

  // memory write port: clearing pass or accepted store
  always_comb begin
    if (clearing) begin
      mem_we    = 1'b1;
      mem_widx  = clr_cnt_r;
      mem_wdata = '0;
      mem_be    = 4'b1111;
    end else begin
      mem_we    = in_beat && acc_ok && !acc_load;
      mem_widx  = acc_idx;
      mem_wdata = st_data;
      mem_be    = st_be;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      for (int i = 0; i < 4; i++) begin
        if (mem_be[i]) begin
          mem[mem_widx][8*i +: 8] <= mem_wdata[8*i +: 8];
        end
      end
    end
  end

  // registered read for accepted loads
  always_ff @(posedge clk) begin
    if (in_beat && acc_ok && acc_load) begin
      rd_word_r <= mem[acc_idx];
    end
  end

  // result stage: load extraction and held value
  assign s_ok    = !s_oor_r && !s_mis_r;
  assign s_load  = (s_func_r != FUNC_SW) && (s_func_r != FUNC_SH) && (s_func_r != FUNC_SB);
  assign ld_half = s_off_r[1] ? rd_word_r[15:0] : rd_word_r[31:16];

  always_comb begin
    case (s_off_r)
      2'd0:    ld_byte = rd_word_r[31:24];
      2'd1:    ld_byte = rd_word_r[23:16];
      2'd2:    ld_byte = rd_word_r[15:8];
      default: ld_byte = rd_word_r[7:0];
    endcase
  end

  always_comb begin
    read_data = held_r;
    if (s_ok) begin
      case (s_func_r)
        FUNC_LW:  read_data = rd_word_r;
        FUNC_LH:  read_data = {{16{ld_half[15]}}, ld_half};
        FUNC_LHU: read_data = {16'h0000, ld_half};
        FUNC_LB:  read_data = {{24{ld_byte[7]}}, ld_byte};
        FUNC_LBU: read_data = {24'h000000, ld_byte};
        default:  read_data = held_r;
      endcase
    end
  end

  always_comb begin
    held_nxt      = held_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      held_nxt      = read_data;
      out_valid_nxt = 1'b0;
    end
    if (in_beat) begin
      out_valid_nxt = 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      held_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      held_r      <= held_nxt;
    end
  end

  // access attributes carried to the result stage
  always_ff @(posedge clk) begin
    if (in_beat) begin
      s_func_r <= in_func;
      s_oor_r  <= acc_oor;
      s_mis_r  <= acc_mis;
      s_off_r  <= in_address[1:0];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = read_data;
  assign out_tuser  = {s_mis_r, s_oor_r};

`include "assert_macros.svh"

  // no access is taken while the memory is being cleared
  `ASSERT_NEVER(a_no_beat_in_clear, clk, rst_n, clearing && in_tready)
  // a result only exists once clearing has finished
  `ASSERT_CLK(a_result_after_clear, clk, rst_n, out_valid_r |-> (state_r == ST_RUN))
  // the held value moves only after a delivered successful load
  `ASSERT_CLK(a_held_on_load, clk, rst_n,
    ($past(rst_n) && !$stable(held_r)) |-> $past(out_valid_r && out_tready && s_ok && s_load))

endmodule
